// ----- hdl/chme_pkg.sv -----
// ----------------------------------------------------------------------------
// Chained hash map engine package
// Shared constants and types for the hash map engine.
// ----------------------------------------------------------------------------
package chme_pkg;

  localparam int InitIndexBits = 10;
  localparam int MaxIndexBits  = 12;
  localparam int NodeCount     = 2048;
  localparam int BucketDepth   = 1 << MaxIndexBits;
  localparam int NodeBits      = $clog2(NodeCount);
  localparam int BucketBits    = MaxIndexBits;
  localparam int IdxWidth      = $clog2(MaxIndexBits + 1);
  localparam int CountBits     = NodeBits + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                  start;
    logic [63:0]           key;
    logic [IdxWidth-1:0]   k;
  } hash_req_t;

  typedef struct packed {
    logic                  done;
    logic [BucketBits-1:0] bucket;
  } hash_rsp_t;

endpackage

// ----- hdl/chme_hash.sv -----
// ----------------------------------------------------------------------------
// Mid-square hash unit
// Computes the bucket index of a key in registered steps: fold, 32-bit partial
// products of the square, their sum, then a combinational extract of the middle bits.
// ----------------------------------------------------------------------------
module chme_hash
  import chme_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  hash_req_t req,
  output hash_rsp_t rsp
);

  logic [3:0]          phase;
  logic [63:0]         h;
  logic [63:0]         acc;
  logic [63:0]         p_ll;
  logic [63:0]         p_lh;
  logic [IdxWidth-1:0] k;

  function automatic logic [63:0] shr(input logic [63:0] v, input logic [6:0] s);
    shr = (s >= 7'd64) ? 64'd0 : (v >> s);
  endfunction

  logic [6:0] k1, k2, k4;
  assign k1 = 7'(k);
  assign k2 = 7'(k) << 1;
  assign k4 = 7'(k) << 2;

  logic [6:0] sh;
  assign sh = (7'd64 - k1) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else begin
      phase <= {phase[2:0], req.start};
    end
    if (req.start) begin
      k <= req.k;
      h <= req.key;
    end
    if (phase[0]) h <= h + shr(h, k1) + shr(h, k2) + shr(h, k4);
    if (phase[1]) begin
      p_ll <= h[31:0] * h[31:0];
      p_lh <= h[31:0] * h[63:32];
    end
    if (phase[2]) acc <= p_ll + {p_lh[30:0], 33'd0};
  end

  logic [63:0] mask;
  assign mask = (64'd1 << k1) - 64'd1;
  assign rsp.done   = phase[3];
  assign rsp.bucket = BucketBits'((acc >> sh) & mask);

endmodule

// ----- hdl/chme_core.sv -----
// ----------------------------------------------------------------------------
// Hash map sequencer
// Holds bucket and node memories and walks chains, inserts, deletes and
// rehashes through a read-modify-write sequencer.
// ----------------------------------------------------------------------------
module chme_core
  import chme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  res_status,
  output logic [63:0] res_value,
  output logic        res_coll
);

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_HASH   = 14'b00000000000100,
    S_BRD    = 14'b00000000001000,
    S_BEVAL  = 14'b00000000010000,
    S_NRD    = 14'b00000000100000,
    S_NEVAL  = 14'b00000001000000,
    S_ALLOC  = 14'b00000010000000,
    S_DONE   = 14'b00000100000000,
    S_RZERO  = 14'b00001000000000,
    S_RSCAN  = 14'b00010000000000,
    S_RKEY   = 14'b00100000000000,
    S_RHASH  = 14'b01000000000000,
    S_RLINK  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [NodeBits-1:0]  bhead_mem [BucketDepth];
  logic [CountBits-1:0] bcnt_mem  [BucketDepth];
  logic [63:0]          nkey_mem  [NodeCount];
  logic [63:0]          nval_mem  [NodeCount];
  logic [NodeBits-1:0]  nnext_mem [NodeCount];
  logic                 used_mem  [NodeCount];

  logic [BucketBits-1:0] b_addr;
  logic                  b_we_head, b_we_cnt;
  logic [NodeBits-1:0]   b_wr_head;
  logic [CountBits-1:0]  b_wr_cnt;
  logic [NodeBits-1:0]   b_rd_head;
  logic [CountBits-1:0]  b_rd_cnt;

  logic [NodeBits-1:0] n_addr;
  logic                n_we_kv, n_we_next, n_we_used;
  logic [63:0]         n_wr_key, n_wr_val;
  logic [NodeBits-1:0] n_wr_next;
  logic                n_wr_used;
  logic [63:0]         n_rd_key, n_rd_val;
  logic [NodeBits-1:0] n_rd_next;
  logic                n_rd_used;

  always_ff @(posedge clk) begin
    if (b_we_head) bhead_mem[b_addr] <= b_wr_head;
    if (b_we_cnt) bcnt_mem[b_addr] <= b_wr_cnt;
    b_rd_head <= bhead_mem[b_addr];
    b_rd_cnt  <= bcnt_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (n_we_kv) begin
      nkey_mem[n_addr] <= n_wr_key;
      nval_mem[n_addr] <= n_wr_val;
    end
    if (n_we_next) nnext_mem[n_addr] <= n_wr_next;
    if (n_we_used) used_mem[n_addr] <= n_wr_used;
    n_rd_key  <= nkey_mem[n_addr];
    n_rd_val  <= nval_mem[n_addr];
    n_rd_next <= nnext_mem[n_addr];
    n_rd_used <= used_mem[n_addr];
  end

  logic [1:0]            op;
  logic [63:0]           key, value;
  logic [IdxWidth-1:0]   kbits;
  logic [CountBits-1:0]  fill;
  logic [BucketBits-1:0] bucket;
  logic [CountBits-1:0]  left;
  logic [NodeBits-1:0]   cur, prev, head;
  logic                  has_prev;
  logic [CountBits-1:0]  bcount;
  logic [NodeBits:0]     scan;
  logic [BucketBits:0]   clr;
  logic                  clr_pool;

  hash_req_t hreq;
  hash_rsp_t hrsp;

  chme_hash u_hash (.clk(clk), .rst(rst), .req(hreq), .rsp(hrsp));

  assign in_ready = (state == S_IDLE) && !res_valid;

  logic [IdxWidth-1:0] init_k;
  assign init_k = IdxWidth'((InitIndexBits < MaxIndexBits) ? InitIndexBits : MaxIndexBits);

  logic grow;
  assign grow = ((CountBits+1)'((1 << kbits) >> 1) < (CountBits+1)'(fill))
                && (kbits < IdxWidth'(MaxIndexBits)) && (fill != '0);

  logic hash_go;
  assign hash_go = (state == S_RKEY && !n_rd_used || state == S_RLINK)
                   && scan == (NodeBits+1)'(NodeCount - 1);

  always_comb begin
    b_addr = bucket; b_we_head = 1'b0; b_we_cnt = 1'b0;
    b_wr_head = cur; b_wr_cnt = '0;
    n_addr = cur; n_we_kv = 1'b0; n_we_next = 1'b0; n_we_used = 1'b0;
    n_wr_key = key; n_wr_val = value; n_wr_next = cur; n_wr_used = 1'b0;
    hreq.start = 1'b0; hreq.key = key; hreq.k = kbits;
    case (state)
      S_CLEAR: begin
        b_addr = clr[BucketBits-1:0];
        n_addr = clr[NodeBits-1:0];
        b_we_cnt = 1'b1;
        n_we_used = clr_pool;
      end
      S_IDLE: begin
        hreq.key = in_key;
        hreq.start = in_valid && in_ready && !(in_op == OP_INSERT && grow);
      end
      S_NRD: n_addr = cur;
      S_NEVAL: begin
        if (op == OP_DELETE && n_rd_key == key && left != '0) begin
          b_we_cnt = 1'b1;
          b_wr_cnt = bcount - 1'b1;
          if (has_prev) begin
            n_addr = prev; n_we_next = 1'b1; n_wr_next = n_rd_next;
          end else begin
            b_we_head = 1'b1; b_wr_head = n_rd_next;
            n_addr = cur; n_we_used = 1'b1; n_wr_used = 1'b0;
          end
        end
      end
      S_ALLOC: begin
        n_addr = scan[NodeBits-1:0];
      end
      S_DONE: begin
        if (has_prev && op == OP_DELETE) begin
          n_addr = cur; n_we_used = 1'b1; n_wr_used = 1'b0;
        end
      end
      S_RZERO: begin
        b_addr = clr[BucketBits-1:0]; b_we_cnt = 1'b1;
      end
      S_RSCAN: n_addr = scan[NodeBits-1:0];
      S_RKEY: begin
        hreq.start = n_rd_used; hreq.key = n_rd_key;
        n_addr = scan[NodeBits-1:0];
      end
      S_RHASH: b_addr = hrsp.bucket;
      S_RLINK: begin
        b_addr = bucket;
        n_addr = scan[NodeBits-1:0];
        n_we_next = 1'b1; n_wr_next = b_rd_head;
        b_we_head = 1'b1; b_wr_head = scan[NodeBits-1:0];
        b_we_cnt = 1'b1; b_wr_cnt = b_rd_cnt + 1'b1;
      end
      default: ;
    endcase
    if (hash_go) begin
      hreq.start = 1'b1; hreq.key = key;
    end
    if (state == S_ALLOC && !n_rd_used && scan != '0) begin
      n_addr = NodeBits'(scan - 1'b1);
      n_we_kv = 1'b1; n_we_used = 1'b1; n_wr_used = 1'b1;
      n_we_next = 1'b1; n_wr_next = (bcount != '0) ? head : '0;
      b_we_head = 1'b1; b_wr_head = NodeBits'(scan - 1'b1);
      b_we_cnt = 1'b1; b_wr_cnt = bcount + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      clr_pool <= 1'b1;
      res_valid <= 1'b0;
      fill <= '0;
      kbits <= init_k;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr[NodeBits-1:0] == NodeBits'(NodeCount - 1)
              && (BucketBits < NodeBits || clr[BucketBits:NodeBits] == '0))
            clr_pool <= 1'b0;
          if (clr == (BucketBits+1)'(BucketDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= in_op; key <= in_key; value <= in_value;
            res_status <= ST_OK; res_value <= '0; res_coll <= 1'b0;
            has_prev <= 1'b0;
            if (in_op == OP_INSERT && grow) begin
              kbits <= kbits + 1'b1;
              clr <= '0;
              state <= S_RZERO;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: if (hrsp.done) begin
          bucket <= hrsp.bucket;
          state <= S_BRD;
        end
        S_BRD: state <= S_BEVAL;
        S_BEVAL: begin
          bcount <= b_rd_cnt; head <= b_rd_head;
          left <= b_rd_cnt; cur <= b_rd_head;
          if (op == OP_QUERY) begin
            res_coll <= (b_rd_cnt > CountBits'(1));
            state <= S_DONE;
          end else if (b_rd_cnt == '0) begin
            if (op == OP_INSERT) begin
              scan <= '0; state <= S_ALLOC;
            end else begin
              res_status <= ST_NOT_FOUND; state <= S_DONE;
            end
          end else begin
            state <= S_NRD;
          end
        end
        S_NRD: state <= S_NEVAL;
        S_NEVAL: begin
          if (n_rd_key == key) begin
            case (op)
              OP_INSERT: res_status <= ST_DUPLICATE;
              OP_FIND: res_value <= n_rd_val;
              OP_DELETE: fill <= fill - 1'b1;
              default: ;
            endcase
            state <= S_DONE;
          end else if (left == CountBits'(1)) begin
            if (op == OP_INSERT) begin
              scan <= '0; state <= S_ALLOC;
            end else begin
              res_status <= ST_NOT_FOUND; has_prev <= 1'b0; state <= S_DONE;
            end
          end else begin
            left <= left - 1'b1;
            prev <= cur; has_prev <= 1'b1;
            cur <= n_rd_next;
            state <= S_NRD;
          end
        end
        S_ALLOC: begin
          has_prev <= 1'b0;
          if (scan != '0 && !n_rd_used) begin
            fill <= fill + 1'b1;
            state <= S_DONE;
          end else if (scan == (NodeBits+1)'(NodeCount)) begin
            res_status <= ST_FULL;
            state <= S_DONE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_DONE: begin
          has_prev <= 1'b0;
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_RZERO: begin
          clr <= clr + 1'b1;
          if (clr == (BucketBits+1)'(BucketDepth - 1)) begin
            scan <= '0; state <= S_RSCAN;
          end
        end
        S_RSCAN: state <= S_RKEY;
        S_RKEY: begin
          if (n_rd_used) state <= S_RHASH;
          else if (scan == (NodeBits+1)'(NodeCount - 1)) state <= S_HASH;
          else begin
            scan <= scan + 1'b1; state <= S_RSCAN;
          end
        end
        S_RHASH: if (hrsp.done) begin
          bucket <= hrsp.bucket; state <= S_RLINK;
        end
        S_RLINK: begin
          if (scan == (NodeBits+1)'(NodeCount - 1)) state <= S_HASH;
          else begin
            scan <= scan + 1'b1; state <= S_RSCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/chained_hash_map_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Chained hash map engine
// Key-to-value table with chained buckets and a mid-square hash.
// ----------------------------------------------------------------------------
// After reset the block clears its bucket counts and node pool and accepts no
// transfer meanwhile. The result of an operation follows the hash and a bucket
// read, plus a node read per chain node visited; a missing key on insert adds
// a scan of the pool up to the lowest free node, or over the whole pool when it
// is full. An insert that widens the table first runs a rehash pass that clears
// the bucket counts, scans the pool and relinks each stored node after hashing
// it. One operation is in flight at a time, and the next transfer is accepted
// from the cycle after the previous result has been taken.
module chained_hash_map_engine_unit
  import chme_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // operation[1:0], key[65:2], value[129:66]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata   // status[1:0], found_value[65:2], collision[66]
);

  logic [1:0]  status;
  logic [63:0] found;
  logic        coll;

  chme_core u_core (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_op(s_tdata[1:0]), .in_key(s_tdata[65:2]), .in_value(s_tdata[129:66]),
    .res_valid(m_tvalid), .res_ready(m_tready),
    .res_status(status), .res_value(found), .res_coll(coll)
  );

  assign m_tdata = {5'd0, coll, found, status};

endmodule

// ----- test/chained_hash_map_engine_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Chained hash map engine testbench
// Drives insert, delete, find and collision-query transfers into the engine
// and checks every result against a behavioral copy of the hash table. It
// covers the table growth steps, a full node pool and back-pressure on both
// sides of the stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_map_engine_unit_tb;
  import chme_pkg::*;

  typedef struct packed {
    logic        collision;
    logic [63:0] found_value;
    status_t     status;
  } result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;  // operation[1:0], key[65:2], value[129:66]
  logic         m_tvalid;
  logic         m_tready;
  logic [71:0]  m_tdata;  // status[1:0], found_value[65:2], collision[66]

  chained_hash_map_engine_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Shadow copy of the hash table.
  logic [10:0] tbl_head [BucketDepth];
  int          tbl_count [BucketDepth];
  logic [63:0] tbl_key [NodeCount];
  logic [63:0] tbl_value [NodeCount];
  logic [10:0] tbl_next [NodeCount];
  bit          tbl_used [NodeCount];
  int          tbl_fill;
  int          tbl_bits;

  result_t     pending_results[$];
  logic [63:0] key_pool [2400];
  int          send_gap_pct;
  int          stall_pct;
  int          hold_left;
  int          fail_count;
  int          items_sent;
  int          results_seen;
  int          growth_count;
  int          full_count;
  int          dup_count;
  int          miss_count;
  int          coll_count;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #(64'd400_000_000);
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int hash_bucket(logic [63:0] key);
    logic [63:0] h;
    logic [63:0] sq;
    h = key + (key >> tbl_bits) + (key >> (2 * tbl_bits)) + (key >> (4 * tbl_bits));
    sq = h * h;
    return int'((sq >> ((64 - tbl_bits) >> 1)) & ((64'd1 << tbl_bits) - 64'd1));
  endfunction

  function automatic int chain_lookup(int b, logic [63:0] key, output int prev);
    int cur;
    prev = -1;
    cur = tbl_head[b];
    for (int i = 0; i < tbl_count[b]; i++) begin
      if (tbl_key[cur] == key) return cur;
      prev = cur;
      cur = tbl_next[cur];
    end
    return -1;
  endfunction

  function automatic void link_into(int node, int b);
    tbl_next[node] = (tbl_count[b] != 0) ? tbl_head[b] : 11'd0;
    tbl_head[b] = node[10:0];
    tbl_count[b]++;
  endfunction

  function automatic result_t apply_op(op_t op, logic [63:0] key, logic [63:0] value);
    result_t r;
    int b;
    int node;
    int prev;
    r = '{status: ST_OK, found_value: 64'd0, collision: 1'b0};
    case (op)
      OP_INSERT: begin
        if (((1 << tbl_bits) >> 1) < tbl_fill && tbl_bits < MaxIndexBits) begin
          tbl_bits++;
          growth_count++;
          for (int i = 0; i < BucketDepth; i++) tbl_count[i] = 0;
          for (int i = 0; i < NodeCount; i++)
            if (tbl_used[i]) link_into(i, hash_bucket(tbl_key[i]));
        end
        b = hash_bucket(key);
        if (chain_lookup(b, key, prev) >= 0) begin
          r.status = ST_DUPLICATE;
        end else begin
          node = -1;
          for (int i = 0; i < NodeCount; i++)
            if (!tbl_used[i]) begin
              node = i;
              break;
            end
          if (node < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_used[node] = 1'b1;
            tbl_key[node] = key;
            tbl_value[node] = value;
            link_into(node, b);
            tbl_fill++;
          end
        end
      end
      OP_DELETE: begin
        b = hash_bucket(key);
        node = chain_lookup(b, key, prev);
        if (node < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (prev < 0) tbl_head[b] = tbl_next[node];
          else tbl_next[prev] = tbl_next[node];
          tbl_count[b]--;
          tbl_used[node] = 1'b0;
          tbl_fill--;
        end
      end
      OP_FIND: begin
        b = hash_bucket(key);
        node = chain_lookup(b, key, prev);
        if (node < 0) r.status = ST_NOT_FOUND;
        else r.found_value = tbl_value[node];
      end
      default: begin
        b = hash_bucket(key);
        r.collision = tbl_count[b] > 1;
      end
    endcase
    return r;
  endfunction

  task automatic send_op(op_t op, logic [63:0] key, logic [63:0] value);
    result_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {6'd0, value, key, op};
    do @(posedge clk); while (!s_tready);
    r = apply_op(op, key, value);
    pending_results.push_back(r);
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel == 0) return 64'd0;
    if (sel == 1) return '1;
    return key_pool[$urandom_range(1499)];
  endfunction

  // Receiver with random stalls and an optional long hold-off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[66:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("Result transfer with no expected result: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.found_value != want.found_value) begin
          $error("found_value: expected %h, actual %h", want.found_value,
                 got.found_value);
          fail_count++;
        end
        if (got.collision != want.collision) begin
          $error("collision: expected %0d, actual %0d", want.collision, got.collision);
          fail_count++;
        end
        case (want.status)
          ST_FULL: full_count++;
          ST_DUPLICATE: dup_count++;
          ST_NOT_FOUND: miss_count++;
          default: ;
        endcase
        if (want.collision) coll_count++;
      end
    end
  end

  task automatic test_directed();
    send_op(OP_FIND, 64'd0, '1);
    send_op(OP_DELETE, 64'd0, 64'd0);
    send_op(OP_QUERY, 64'd0, 64'd0);
    send_op(OP_INSERT, 64'd0, 64'h5555_5555_5555_5555);
    send_op(OP_INSERT, '1, '1);
    send_op(OP_INSERT, 64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(OP_INSERT, 64'd0, 64'd7);
    send_op(OP_FIND, 64'd0, 64'd0);
    send_op(OP_FIND, '1, 64'd0);
    send_op(OP_FIND, 64'h8000_0000_0000_0001, '1);
    send_op(OP_FIND, 64'd12345, 64'd0);
    send_op(OP_QUERY, '1, '1);
    send_op(OP_QUERY, 64'h8000_0000_0000_0001, 64'd0);
    send_op(OP_DELETE, '1, 64'd0);
    send_op(OP_FIND, '1, 64'd0);
    send_op(OP_DELETE, '1, 64'd0);
    send_op(OP_INSERT, '1, 64'd0);
    send_op(OP_INSERT, 64'd1, 64'd1);
    send_op(OP_INSERT, 64'd2, 64'd2);
    send_op(OP_QUERY, 64'd1, 64'd0);
    wait_drain();
  endtask

  task automatic test_random(int count);
    int sel;
    op_t op;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      op = sel < 55 ? OP_INSERT : sel < 70 ? OP_DELETE : sel < 85 ? OP_FIND : OP_QUERY;
      send_op(op, pick_key(), {$urandom, $urandom});
    end
    wait_drain();
  endtask

  task automatic test_pressure();
    hold_left = 400;
    for (int i = 0; i < 8; i++) send_op(OP_FIND, pick_key(), 64'd0);
    wait_drain();
  endtask

  task automatic test_full_pool();
    while (tbl_fill < NodeCount) send_op(OP_INSERT, {$urandom, $urandom}, {$urandom, $urandom});
    send_op(OP_INSERT, {$urandom, $urandom}, 64'd1);
    send_op(OP_INSERT, 64'hDEAD_0000_0000_0001, 64'd2);
    for (int i = 0; i < 20; i++) send_op(OP_DELETE, pick_key(), 64'd0);
    for (int i = 0; i < 30; i++) send_op(OP_INSERT, pick_key(), {$urandom, $urandom});
    for (int i = 0; i < 20; i++) send_op(op_t'($urandom_range(3)), pick_key(), 64'd0);
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    hold_left = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    growth_count = 0;
    full_count = 0;
    dup_count = 0;
    miss_count = 0;
    coll_count = 0;
    tbl_fill = 0;
    tbl_bits = InitIndexBits < MaxIndexBits ? InitIndexBits : MaxIndexBits;
    for (int i = 0; i < BucketDepth; i++) tbl_count[i] = 0;
    for (int i = 0; i < NodeCount; i++) tbl_used[i] = 1'b0;
    for (int i = 0; i < 2400; i++)
      key_pool[i] = (i < 64) ? 64'(i) : {$urandom, $urandom};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    send_gap_pct = 73;
    test_random(100);
    send_gap_pct = 0;
    stall_pct = 73;
    test_random(100);
    send_gap_pct = 18;
    stall_pct = 18;
    test_random(100);
    send_gap_pct = 0;
    stall_pct = 0;
    test_random(100);
    test_pressure();
    send_gap_pct = 18;
    stall_pct = 18;
    test_full_pool();

    repeat (200) @(posedge clk);
    $display("Sent %0d operations, checked %0d results; %0d table growths.",
             items_sent, results_seen, growth_count);
    $display("Pool full %0d, duplicates %0d, misses %0d, collisions %0d.",
             full_count, dup_count, miss_count, coll_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
